FILE: sv/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg: shared types and constants of the slab bitmap allocator
// Holds the size-class geometry, the status codes and the control structs
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int NumClasses = 4;
  localparam int MaxSlots   = 256;
  localparam int OffsetBits = 24;
  localparam int ClsW       = $clog2(NumClasses);
  localparam int SlotW      = $clog2(MaxSlots);
  localparam int SlotCntW   = 9;
  localparam int BlkW       = 13;
  localparam int SpanW      = BlkW + SlotCntW;
  localparam int BaseW      = SpanW + ClsW + 1;
  localparam int ReqW       = 32;
  localparam int CfgIdxW    = 3;
  localparam int MapDepth   = NumClasses * MaxSlots;
  localparam int MapAw      = $clog2(MapDepth);

  localparam logic [2:0] ST_ALLOC     = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_FREED     = 3'd3;
  localparam logic [2:0] ST_IGNORED   = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic load;      // capture the request, reset the walk
    logic cls_step;  // advance the class walk by one class
    logic scan_step; // read the next map entry / next divide step
    logic mark;      // write the map entry
    logic set_out;   // load the result register
  } sba_cmd_t;

  typedef struct packed {
    logic cls_done;   // class walk resolved
    logic cls_none;   // no class matched
    logic is_alloc;
    logic scan_hit;   // free slot found (alloc) or division finished (free)
    logic scan_end;   // scan ran out of slots
    logic free_ok;    // free division result valid
  } sba_sts_t;

endpackage

FILE: sv/sba_datapath.sv
// ----------------------------------------------------------------------------
// sba_datapath: class walk, bitmap memory, slot scan and offset divider
// One class or quotient bit per cycle; each bitmap entry is read, then checked.
// ----------------------------------------------------------------------------
module sba_datapath import sba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CfgIdxW-1:0]    cfg_idx,
  input  logic [15:0]           cfg_val,
  input  logic                  req_op,
  input  logic [ReqW-1:0]       req_size,
  input  logic [OffsetBits-1:0] req_off,
  input  logic                  req_null,
  input  logic                  clr_we,
  input  logic [MapAw-1:0]      clr_addr,
  input  sba_cmd_t              cmd,
  output sba_sts_t              sts,
  output logic [2:0]            res_status,
  output logic [OffsetBits-1:0] res_offset
);

  logic [BlkW-1:0]     blk_r   [NumClasses];
  logic [SlotCntW-1:0] slots_r [NumClasses];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NumClasses; c++) begin
        blk_r[c]   <= BlkW'(16 << c);
        slots_r[c] <= SlotCntW'(64);
      end
    end else if (cfg_we) begin
      if (cfg_idx[2] == 1'b0) blk_r[cfg_idx[1:0]] <= cfg_val[BlkW-1:0];
      else                    slots_r[cfg_idx[1:0]] <= cfg_val[SlotCntW-1:0];
    end
  end

  // captured request
  logic                  op_r, null_r;
  logic [ReqW-1:0]       size_r;
  logic [OffsetBits-1:0] off_r;

  // class walk
  logic [ClsW:0]   cls_r;
  logic [BaseW-1:0] base_r;
  logic            done_r, none_r;
  logic [ClsW-1:0] cls_i;
  logic [BlkW-1:0] blk_c;
  logic [SlotCntW-1:0] use_c;
  logic [SpanW-1:0] span_c;
  logic            match_c;

  assign cls_i  = cls_r[ClsW-1:0];
  assign blk_c  = blk_r[cls_i];
  assign use_c  = (slots_r[cls_i] > SlotCntW'(MaxSlots)) ? SlotCntW'(MaxSlots)
                                                          : slots_r[cls_i];
  assign span_c = SpanW'(blk_c) * SpanW'(use_c);
  always_comb begin
    if (op_r == OP_ALLOC) match_c = size_r <= ReqW'(blk_c);
    else match_c = (span_c != '0) && (BaseW'(off_r) >= base_r) &&
                   (BaseW'(off_r) < base_r + BaseW'(span_c));
  end

  // scan / divide
  logic [SlotW:0]      idx_r;
  logic [BaseW-1:0]    rem_r;
  logic [BaseW-1:0]    gofs_r;
  logic [SlotW+1:0]    qbit_r;
  logic                hit_r, end_r, fok_r;
  logic                rd_busy_r, rd_pend_r;
  logic [SlotCntW-1:0] use_r;
  logic [BlkW-1:0]     blk_sel_r;

  // bitmap memory
  logic              map_mem [MapDepth];
  logic              wr_en;
  logic [MapAw-1:0]  wr_addr, rd_addr;
  logic              wr_val;

  assign rd_addr = {cls_i, idx_r[SlotW-1:0]};
  always_comb begin
    wr_en = clr_we; wr_addr = clr_addr; wr_val = 1'b0;
    if (cmd.mark) begin
      wr_en = 1'b1; wr_addr = rd_addr; wr_val = (op_r == OP_ALLOC);
    end
  end
  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_val;
    rd_busy_r <= map_mem[rd_addr];
  end

  logic [BaseW-1:0] dsub;
  assign dsub = BaseW'(blk_sel_r) << qbit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0; none_r <= 1'b0; hit_r <= 1'b0; end_r <= 1'b0;
      fok_r <= 1'b0; rd_pend_r <= 1'b0; cls_r <= '0;
    end else if (cmd.load) begin
      op_r <= req_op; null_r <= req_null; size_r <= req_size; off_r <= req_off;
      cls_r <= '0; base_r <= '0; done_r <= 1'b0; none_r <= 1'b0;
      hit_r <= 1'b0; end_r <= 1'b0; fok_r <= 1'b0; rd_pend_r <= 1'b0;
      idx_r <= '0;
    end else if (cmd.cls_step) begin
      if (cls_r == (ClsW+1)'(NumClasses) || (op_r == OP_FREE && null_r)) begin
        done_r <= 1'b1; none_r <= 1'b1;
      end else if (match_c) begin
        done_r <= 1'b1; use_r <= use_c; blk_sel_r <= blk_c;
        rem_r <= BaseW'(off_r) - base_r; gofs_r <= base_r;
        qbit_r <= (SlotW+2)'(SlotW + 1); idx_r <= '0;
      end else begin
        cls_r <= cls_r + 1'b1; base_r <= base_r + BaseW'(span_c);
      end
    end else if (cmd.scan_step) begin
      if (op_r == OP_ALLOC) begin
        // read pipelined: address idx_r, data next cycle
        if (!rd_pend_r) begin
          if (idx_r >= (SlotW+1)'(use_r)) end_r <= 1'b1;
          else rd_pend_r <= 1'b1;
        end else begin
          rd_pend_r <= 1'b0;
          if (!rd_busy_r) hit_r <= 1'b1;
          else begin
            idx_r <= idx_r + 1'b1; gofs_r <= gofs_r + BaseW'(blk_sel_r);
          end
        end
      end else begin
        // restoring divide, one quotient bit per cycle
        if (rem_r >= dsub) begin
          rem_r <= rem_r - dsub;
          idx_r <= idx_r | ((SlotW+1)'(1) << qbit_r);
        end
        if (qbit_r == '0) begin
          hit_r <= 1'b1;
          fok_r <= ((rem_r >= dsub) ? (rem_r - dsub) : rem_r) == '0;
        end else qbit_r <= qbit_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_out) begin
      res_offset <= '0;
      if (op_r == OP_ALLOC) begin
        if (none_r)      res_status <= ST_TOO_LARGE;
        else if (end_r)  res_status <= ST_EXHAUSTED;
        else begin
          res_status <= ST_ALLOC; res_offset <= gofs_r[OffsetBits-1:0];
        end
      end else begin
        res_status <= (!none_r && fok_r) ? ST_FREED : ST_IGNORED;
      end
    end
  end

  assign sts.cls_done = done_r;
  assign sts.cls_none = none_r;
  assign sts.is_alloc = (op_r == OP_ALLOC);
  assign sts.scan_hit = hit_r;
  assign sts.scan_end = end_r;
  assign sts.free_ok  = fok_r;

endmodule

FILE: sv/sba_ctrl.sv
// ----------------------------------------------------------------------------
// sba_ctrl: request sequencer and bitmap clearing pass
// Walks clear, idle, class search, scan, mark and result hand-off.
// ----------------------------------------------------------------------------
module sba_ctrl import sba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             out_free,
  input  sba_sts_t         sts,
  output sba_cmd_t         cmd,
  output logic             idle,
  output logic             clr_we,
  output logic [MapAw-1:0] clr_addr,
  output logic             res_valid_set
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLS   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [MapAw:0]   clr_r, clr_nxt;

  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r; cmd = '0; res_valid_set = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (MapAw+1)'(MapDepth - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1; state_nxt = S_CLS;
      end
      S_CLS: begin
        if (sts.cls_done) state_nxt = sts.cls_none ? S_OUT : S_SCAN;
        else cmd.cls_step = 1'b1;
      end
      S_SCAN: begin
        if (sts.scan_end) state_nxt = S_OUT;
        else if (sts.scan_hit)
          state_nxt = (sts.is_alloc || sts.free_ok) ? S_MARK : S_OUT;
        else cmd.scan_step = 1'b1;
      end
      S_MARK: begin
        cmd.mark = 1'b1; state_nxt = S_OUT;
      end
      S_OUT: if (out_free) begin
        cmd.set_out = 1'b1; res_valid_set = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt;
    end
  end

  assign idle     = (state_r == S_IDLE);
  assign clr_we   = (state_r == S_CLEAR);
  assign clr_addr = clr_r[MapAw-1:0];

endmodule

FILE: sv/slab_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// slab_bitmap_allocator_core: four-class slab allocator with busy bitmap
// Allocate claims the lowest free slot of the first fitting class; free
// divides the offset by the class block size and clears that slot.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit first)                          | tuser
//  in_     | in  | opcode, request_size, block_offset, null, pad   | -
//  out_    | out | status, granted_offset, pad                     | -
//  cfg_    | in  | cfg_index (3b), cfg_data (16b)                  | -
//
//  sequence: accept, class walk, then for alloc a slot scan in which each
//    slot looked at takes a registered bitmap read and then a check, or for
//    free a restoring divide, then a mark (only on a grant or a valid free)
//    and the result
//  reset: bitmap clearing pass over all 1024 entries, in_tready low meanwhile
//  stalls: the result register holds until taken; the next transaction is
//    accepted while the previous result still waits at the output
// ----------------------------------------------------------------------------
module slab_bitmap_allocator_core import sba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // opcode, request_size, block_offset, offset_is_null
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status, granted_offset
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  sba_cmd_t cmd;
  sba_sts_t sts;
  logic idle, clr_we, res_set, in_fire, out_free;
  logic [MapAw-1:0] clr_addr;
  logic [2:0] res_status;
  logic [OffsetBits-1:0] res_offset;
  logic out_valid_r;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;
  // result register frees when empty or being taken this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  sba_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_free, .sts, .cmd, .idle,
    .clr_we, .clr_addr, .res_valid_set(res_set)
  );

  sba_datapath u_dp (
    .clk, .rst_n,
    .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .req_op(in_tdata[0]), .req_size(in_tdata[32:1]),
    .req_off(in_tdata[56:33]), .req_null(in_tdata[57]),
    .clr_we, .clr_addr, .cmd, .sts, .res_status, .res_offset
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_set) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_offset, res_status};

  // no transaction taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_we |-> !in_tready) else $error("accept during bitmap clear");
  // a non-alloc result carries a zero offset
  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2:0] != ST_ALLOC) |-> out_tdata[26:3] == '0)
    else $error("offset on failed request");
  // result load only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_set |-> out_free) else $error("result overwritten");

endmodule

FILE: sim/tb_slab_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_slab_bitmap_allocator_core: self-checking bench for the slab allocator
// Drives allocate and free transactions under several class geometries and
// handshake idling patterns, predicts each status and granted offset with
// a behavioral copy of the class bitmap, and compares in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_slab_bitmap_allocator_core;
  import sba_pkg::*;

  // register indexes of the configuration channel
  localparam logic [2:0] REG_BLK0 = 3'd0;
  localparam logic [2:0] REG_CNT0 = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] granted;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // predictor state
  int unsigned   blk_size [NumClasses];
  int unsigned   slot_cnt [NumClasses];
  bit            busy_map [NumClasses][MaxSlots];
  alloc_result_t expected_results[$];
  int            fail_count = 0;

  // idling knobs: percent of cycles, and a receiver hold-off in cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  slab_bitmap_allocator_core DUT (.*);

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  // predict one request, mirroring the allocator rules
  function automatic alloc_result_t predict_request(logic op, logic [31:0] req,
                                                    logic [23:0] off, logic is_null);
    alloc_result_t r;
    longint unsigned base, span, rel;
    int unsigned slots;
    bit done;
    r.status = ST_IGNORED;
    r.granted = '0;
    base = 0;
    done = 0;
    if (op == OP_ALLOC) begin
      r.status = ST_TOO_LARGE;
      for (int c = 0; c < NumClasses && !done; c++) begin
        slots = (slot_cnt[c] > MaxSlots) ? MaxSlots : slot_cnt[c];
        if (req <= blk_size[c]) begin
          r.status = ST_EXHAUSTED;
          for (int i = 0; i < slots; i++) begin
            if (!busy_map[c][i]) begin
              busy_map[c][i] = 1;
              r.granted = 24'(base + longint'(i) * blk_size[c]);
              r.status = ST_ALLOC;
              break;
            end
          end
          done = 1;
        end else begin
          base += longint'(blk_size[c]) * slots;
        end
      end
    end else if (!is_null) begin
      for (int c = 0; c < NumClasses && !done; c++) begin
        slots = (slot_cnt[c] > MaxSlots) ? MaxSlots : slot_cnt[c];
        span = longint'(blk_size[c]) * slots;
        if (span != 0 && off >= base && off < base + span) begin
          rel = off - base;
          if (rel % blk_size[c] == 0 && rel / blk_size[c] < slots) begin
            busy_map[c][rel / blk_size[c]] = 0;
            r.status = ST_FREED;
          end
          done = 1;
        end
        base += span;
      end
    end
    return r;
  endfunction

  // region base of a class under the current geometry
  function automatic longint unsigned class_base(int cls);
    longint unsigned b = 0;
    for (int c = 0; c < cls; c++)
      b += longint'(blk_size[c]) * ((slot_cnt[c] > MaxSlots) ? MaxSlots : slot_cnt[c]);
    return b;
  endfunction

  task automatic send_request(logic op, logic [31:0] req, logic [23:0] off,
                              logic is_null);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
      @(negedge clk);
    in_tdata <= {6'd0, is_null, off, req, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(predict_request(op, req, off, is_null));
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic write_register(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < REG_CNT0) blk_size[idx] = val & 16'h1FFF;
    else slot_cnt[idx - REG_CNT0] = val & 16'h01FF;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every outstanding result arrived, plus a worst-case walk
  task automatic drain_results();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (1100) @(negedge clk);
  endtask

  task automatic set_geometry(int unsigned b0, b1, b2, b3, n0, n1, n2, n3);
    drain_results();
    write_register(REG_BLK0 + 3'd0, 16'(b0));
    write_register(REG_BLK0 + 3'd1, 16'(b1));
    write_register(REG_BLK0 + 3'd2, 16'(b2));
    write_register(REG_BLK0 + 3'd3, 16'(b3));
    write_register(REG_CNT0 + 3'd0, 16'(n0));
    write_register(REG_CNT0 + 3'd1, 16'(n1));
    write_register(REG_CNT0 + 3'd2, 16'(n2));
    write_register(REG_CNT0 + 3'd3, 16'(n3));
  endtask

  // random free of a slot in a random class, occasionally misaligned or null
  task automatic send_random_free();
    int c = $urandom_range(NumClasses - 1);
    int unsigned slots = (slot_cnt[c] > MaxSlots) ? MaxSlots : slot_cnt[c];
    longint unsigned o = class_base(c);
    if (slots != 0) o += longint'($urandom_range(slots - 1)) * blk_size[c];
    if ($urandom_range(9) == 0) o += $urandom_range(3);
    send_request(OP_FREE, $urandom, 24'(o), $urandom_range(15) == 0);
  endtask

  task automatic send_random_alloc();
    logic [31:0] sz;
    case ($urandom_range(5))
      0: sz = $urandom;
      1: sz = 0;
      default: sz = $urandom_range(blk_size[NumClasses - 1] + 2);
    endcase
    send_request(OP_ALLOC, sz, 24'($urandom), $urandom_range(1));
  endtask

  task automatic random_mix(int n);
    repeat (n) begin
      if ($urandom_range(99) < 55) send_random_alloc();
      else if ($urandom_range(9) == 0)
        send_request(OP_FREE, $urandom, 24'($urandom), 1'($urandom));
      else send_random_free();
    end
  endtask

  // result checker: samples at the rising edge
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: %h", out_tdata);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_tdata[2:0] !== e.status) begin
          $error("status mismatch: expected %0d actual %0d", e.status, out_tdata[2:0]);
          fail_count++;
        end
        if (out_tdata[26:3] !== e.granted) begin
          $error("granted_offset mismatch: expected %h actual %h",
                 e.granted, out_tdata[26:3]);
          fail_count++;
        end
      end
    end
  end

  // receiver ready, with random stalls and a counted long hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic test_directed();
    // exact fit, one above, zero size, beyond the largest class
    send_request(OP_ALLOC, 32'd16, 24'd0, 1'b0);
    send_request(OP_ALLOC, 32'd17, 24'd0, 1'b0);
    send_request(OP_ALLOC, 32'd0, 24'hFFFFFF, 1'b1);
    send_request(OP_ALLOC, 32'd128, 24'd0, 1'b0);
    send_request(OP_ALLOC, 32'd129, 24'd0, 1'b0);
    send_request(OP_ALLOC, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1);
    // freed, double free, null, misaligned, beyond the heap
    send_request(OP_FREE, 32'd0, 24'd0, 1'b0);
    send_request(OP_FREE, 32'd0, 24'd0, 1'b0);
    send_request(OP_FREE, 32'hFFFFFFFF, 24'd1024, 1'b1);
    send_request(OP_FREE, 32'd0, 24'd1025, 1'b0);
    send_request(OP_FREE, 32'd0, 24'hFFFFFF, 1'b0);
    send_request(OP_FREE, 32'd0, 24'd3072, 1'b0);
    // exhaust a small class, then free inside it
    set_geometry(8, 0, 24, 4096, 2, 300, 0, 256);
    repeat (3) send_request(OP_ALLOC, 32'd5, 24'd0, 1'b0);
    send_request(OP_ALLOC, 32'd0, 24'd0, 1'b0);       // class 0 full
    send_request(OP_FREE, 32'd0, 24'd8, 1'b0);
    send_request(OP_FREE, 32'd0, 24'd16, 1'b0);       // lands in class 3, past the zero-size classes
    send_request(OP_ALLOC, 32'd20, 24'd0, 1'b0);      // class 2 has no slots
    send_request(OP_ALLOC, 32'd4096, 24'd0, 1'b0);
    send_request(OP_FREE, 32'd0, 24'd16 + 24'd4096 * 24'd255, 1'b0);
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  random_mix(90);
    set_geometry(1, 2, 3, 4, 8, 8, 8, 8);
    send_idle_pct = 62; recv_stall_pct = 0;  random_mix(90);
    set_geometry(16, 32, 64, 128, 64, 64, 64, 64);
    send_idle_pct = 0;  recv_stall_pct = 62; random_mix(90);
    // largest heap of the phases; the count of 511 is clamped to 256 slots
    set_geometry(4096, 4096, 4096, 4096, 256, 256, 256, 511);
    send_idle_pct = 37; recv_stall_pct = 37; random_mix(60);
    set_geometry(12, 40, 100, 1000, 16, 10, 6, 4);
    send_idle_pct = 37; recv_stall_pct = 37; random_mix(90);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 400;
    random_mix(20);
    // pause until every result has come back, then resume
    while (expected_results.size() != 0) @(negedge clk);
    random_mix(20);
  endtask

  initial begin
    for (int c = 0; c < NumClasses; c++) begin
      blk_size[c] = 16 << c;
      slot_cnt[c] = 64;
      for (int i = 0; i < MaxSlots; i++) busy_map[c][i] = 0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_phases();
    test_backpressure();
    drain_results();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
